### src/butterworth_lowpass_iir5_top_macros.svh
// Assertion macros for the fifth-order low-pass filter block.
// Included by files that check their own logic; relies on clk and rst in scope.
`ifndef BUTTERWORTH_LOWPASS_IIR5_TOP_MACROS_SVH
`define BUTTERWORTH_LOWPASS_IIR5_TOP_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define BWL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define BWL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bwl_pkg.sv
// Shared constants and coefficient helper for the fifth-order low-pass filter.
// No dependencies; imported by the top level.
package bwl_pkg;

  // Stored output history format: signed Q4.20.
  localparam int HIST_W    = 24;
  localparam int HIST_FRAC = 20;

  // Coefficients are given as integers over this decimal scale.
  localparam int DEC_SCALE = 10000;

  localparam int FF_TAPS = 6;
  localparam int FB_TAPS = 5;

  // Feedforward b0..b5 and feedback a1..a5, scaled by DEC_SCALE.
  localparam int FF_DEC [FF_TAPS] = '{13, 64, 128, 128, 64, 13};
  localparam int FB_DEC [FB_TAPS] = '{29754, -38060, 25453, -8811, 1254};

  // Round the magnitude half up to frac fraction bits, then restore the sign.
  function automatic longint coef_fixed(input int dec, input int frac);
    longint mag;
    longint val;
    mag = (dec < 0) ? -longint'(dec) : longint'(dec);
    val = ((mag <<< frac) + longint'(DEC_SCALE / 2)) / DEC_SCALE;
    return (dec < 0) ? -val : val;
  endfunction

endpackage

### src/bwl_cell.sv
// One tap cell of the transposed filter chain: a partial sum register.
// Self-contained; instantiated in rows by the top level.
module bwl_cell #(
  parameter int DATA_W = 16,
  parameter int COEF_W = 23,
  parameter int SUM_W  = 48,
  parameter logic signed [COEF_W-1:0] COEF = '0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] data,
  input  logic signed [SUM_W-1:0]  sum_in,
  output logic signed [SUM_W-1:0]  sum
);

  localparam int PROD_W = DATA_W + COEF_W;

  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum_next;

  // Weight the new value and add the neighbour's partial sum
  assign prod     = PROD_W'(data) * PROD_W'(COEF);
  assign sum_next = sum_in + SUM_W'(prod);

  // Advance the partial sum once per request; history starts at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (en) begin
      sum <= sum_next;
    end
  end

endmodule

### src/bwl_round.sv
// Round half up by a fixed shift, then saturate to a narrower signed word.
// Self-contained; used for the stored history and for the output sample.
module bwl_round #(
  parameter int IN_W  = 64,
  parameter int SHIFT = 35,
  parameter int OUT_W = 24
) (
  input  logic signed [IN_W-1:0]  value,
  output logic signed [OUT_W-1:0] rounded,
  output logic                    clipped
);

  localparam int EXT_W = IN_W + 1;
  localparam logic signed [EXT_W-1:0] HALF = EXT_W'(1) << (SHIFT - 1);
  localparam logic signed [EXT_W-1:0] HI =
    {{(EXT_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [EXT_W-1:0] LO = ~HI;

  logic signed [EXT_W-1:0] biased;
  logic signed [EXT_W-1:0] shifted;

  // Add half an output step, then drop the fraction towards minus infinity
  assign biased  = EXT_W'(value) + HALF;
  assign shifted = biased >>> SHIFT;

  // Clip to the signed output range
  always_comb begin
    if (shifted > HI) begin
      rounded = HI[OUT_W-1:0];
      clipped = 1'b1;
    end else if (shifted < LO) begin
      rounded = LO[OUT_W-1:0];
      clipped = 1'b1;
    end else begin
      rounded = shifted[OUT_W-1:0];
      clipped = 1'b0;
    end
  end

endmodule

### src/butterworth_lowpass_iir5_top.sv
// Fifth-order Butterworth low-pass filter, fixed coefficients, transposed cell chains.
// Depends on bwl_pkg, bwl_cell, bwl_round and the assertion macro header.
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+---------------------
//   sample   | in        | sample_valid / sample_stall | sample
//   result   | out       | result_valid / result_stall | filtered, saturated
//
// One sample per cycle unless results stall; stage one feeds the output register.
// The pace is set by the feedback loop: stored output, rounding, first feedback cell.
// Reset clears the partial sums of both chains at once, so history starts at zero.
// A stalled result holds; one further request is still taken into the first stage.
`include "butterworth_lowpass_iir5_top_macros.svh"

module butterworth_lowpass_iir5_top
  import bwl_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic signed [SAMPLE_WIDTH-1:0] filtered,
  output logic                           saturated
);

  localparam int COEF_W   = COEF_FRAC_BITS + 3;
  localparam int FF_W     = COEF_W + SAMPLE_WIDTH + 3;
  localparam int FB_W     = COEF_W + HIST_W + 3;
  localparam int XF       = SAMPLE_WIDTH - 1;
  localparam int TOP      = (HIST_FRAC > XF) ? HIST_FRAC : XF;
  localparam int FF_SH    = TOP - XF;
  localparam int FB_SH    = TOP - HIST_FRAC;
  localparam int FF_EXT_W = FF_W + FF_SH;
  localparam int FB_EXT_W = FB_W + FB_SH;
  localparam int ACC_W    = ((FF_EXT_W > FB_EXT_W) ? FF_EXT_W : FB_EXT_W) + 1;
  localparam int ACC_FRAC = COEF_FRAC_BITS + TOP;
  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = ~OUT_MAX;

  logic                           stage1_valid;
  logic                           out_open;
  logic                           advance;
  logic                           accept;
  logic signed [ACC_W-1:0]        acc;
  logic signed [HIST_W-1:0]       hist_new;
  logic                           hist_clip;
  logic signed [SAMPLE_WIDTH-1:0] y_new;
  logic                           y_clip;
  logic                           at_limit;

  wire signed [FF_W-1:0] ff_sum [0:FF_TAPS];
  wire signed [FB_W-1:0] fb_sum [0:FB_TAPS];

  // Handshake: the first stage moves on when the output register is free or being taken
  assign out_open     = !result_valid || !result_stall;
  assign advance      = stage1_valid && out_open;
  assign sample_stall = stage1_valid && !out_open;
  assign accept       = sample_valid && !sample_stall;

  // Feedforward chain: cell zero ends up holding the full b-weighted sum
  assign ff_sum[FF_TAPS] = '0;
  for (genvar k = 0; k < FF_TAPS; k++) begin : g_ff
    localparam logic signed [COEF_W-1:0] B =
      COEF_W'(coef_fixed(FF_DEC[k], COEF_FRAC_BITS));
    bwl_cell #(
      .DATA_W (SAMPLE_WIDTH),
      .COEF_W (COEF_W),
      .SUM_W  (FF_W),
      .COEF   (B)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (accept),
      .data   (sample),
      .sum_in (ff_sum[k+1]),
      .sum    (ff_sum[k])
    );
  end

  // Feedback chain: cell zero holds the a-weighted sum of past stored outputs
  assign fb_sum[FB_TAPS] = '0;
  for (genvar k = 0; k < FB_TAPS; k++) begin : g_fb
    localparam logic signed [COEF_W-1:0] A =
      COEF_W'(coef_fixed(FB_DEC[k], COEF_FRAC_BITS));
    bwl_cell #(
      .DATA_W (HIST_W),
      .COEF_W (COEF_W),
      .SUM_W  (FB_W),
      .COEF   (A)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (advance),
      .data   (hist_new),
      .sum_in (fb_sum[k+1]),
      .sum    (fb_sum[k])
    );
  end

  // Align both sums to a common fraction and add
  assign acc = (ACC_W'(ff_sum[0]) <<< FF_SH) + (ACC_W'(fb_sum[0]) <<< FB_SH);

  // Stored history value, fed back into the chain
  bwl_round #(
    .IN_W  (ACC_W),
    .SHIFT (ACC_FRAC - HIST_FRAC),
    .OUT_W (HIST_W)
  ) u_round_hist (
    .value   (acc),
    .rounded (hist_new),
    .clipped (hist_clip)
  );

  // Output sample, taken from the full sum
  bwl_round #(
    .IN_W  (ACC_W),
    .SHIFT (ACC_FRAC - XF),
    .OUT_W (SAMPLE_WIDTH)
  ) u_round_out (
    .value   (acc),
    .rounded (y_new),
    .clipped (y_clip)
  );

  // Track a request waiting in the first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
    end else if (accept) begin
      stage1_valid <= 1'b1;
    end else if (advance) begin
      stage1_valid <= 1'b0;
    end
  end

  // Output register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      filtered  <= y_new;
      saturated <= y_clip;
    end
  end

  // A clipped output sits on one of the two range limits
  assign at_limit = (filtered == OUT_MAX) || (filtered == OUT_MIN);

  `BWL_ASSERT_NEXT(a_accept_fills_stage1, accept, stage1_valid, "request lost in stage one")
  `BWL_ASSERT_NEXT(a_advance_loads_result, advance, result_valid, "advance gave no result")
  `BWL_ASSERT_NOW(a_stage1_free, !stage1_valid, !sample_stall, "stalled with stage one empty")
  `BWL_ASSERT_NOW(a_clip_at_limit, result_valid && saturated, at_limit, "clip not at a limit")
  `BWL_ASSERT_NOW(a_hist_clip_out_clip, hist_clip, y_clip, "history clipped, output not")

endmodule

### bench/testbench.sv
// Self-checking bench for the fifth-order low-pass filter top level.
// Drives directed and random sample requests against a cycle-free predictor of the filter;
// needs only butterworth_lowpass_iir5_top and the files it depends on.
`timescale 1ns / 1ps

module testbench;

  localparam int SW         = 16;
  localparam int HIST_BITS  = 24;
  localparam int STEP_SHIFT = 5;    // input fraction 15 lifted to history fraction 20
  localparam int HIST_SHIFT = 20;   // accumulator fraction 40 down to Q4.20
  localparam int OUT_SHIFT  = 25;   // accumulator fraction 40 down to Q1.15
  localparam int N_ITEMS    = 900;
  localparam int TAIL_ITEMS = 120;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic signed [SW-1:0] filtered;
    logic                 saturated;
  } filt_result_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  logic signed [SW-1:0] sample       = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic signed [SW-1:0] filtered;
  logic                 saturated;

  butterworth_lowpass_iir5_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered     (filtered),
    .saturated    (saturated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Filter coefficients as four-decimal integers, rounded to Q3.20; taps b0..b5 and a1..a5.
  const int ff_dec [6] = '{13, 64, 128, 128, 64, 13};
  const int fb_dec [5] = '{29754, -38060, 25453, -8811, 1254};
  longint ff_coef [6];
  longint fb_coef [5];

  // Delay lines x[n-1]..x[n-5] and y[n-1]..y[n-5].
  logic signed [SW-1:0]        x_delay [5];
  logic signed [HIST_BITS-1:0] y_delay [5];

  logic signed [SW-1:0] samples_to_send [$];
  filt_result_t         expected_filtered [$];
  int                   mismatches = 0;
  int                   send_gap   = 0;
  int                   stall_left = 0;
  int                   idle_cycles = 0;
  logic                 quiet_tail;

  assign quiet_tail = (samples_to_send.size() < TAIL_ITEMS);

  // Round a four-decimal coefficient half up in magnitude to 20 fraction bits.
  function automatic longint to_q20(input int dec);
    longint mag;
    mag = (dec < 0) ? -longint'(dec) : longint'(dec);
    mag = ((mag <<< 20) + 64'sd5000) / 64'sd10000;
    return (dec < 0) ? -mag : mag;
  endfunction

  // Advance the filter by one sample and return the result it gives.
  function automatic filt_result_t filter_step(input logic signed [SW-1:0] x);
    longint       fwd, back, acc, hist_new, y_wide;
    filt_result_t res;
    fwd = ff_coef[0] * longint'(x);
    back = 0;
    for (int i = 0; i < 5; i++) begin
      fwd  += ff_coef[i+1] * longint'(x_delay[i]);
      back += fb_coef[i] * longint'(y_delay[i]);
    end
    acc = (fwd <<< STEP_SHIFT) + back;

    hist_new = (acc + (64'sd1 <<< (HIST_SHIFT - 1))) >>> HIST_SHIFT;
    if (hist_new > 64'sd8388607) hist_new = 64'sd8388607;
    if (hist_new < -64'sd8388608) hist_new = -64'sd8388608;

    y_wide = (acc + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    res.saturated = 1'b0;
    if (y_wide > 64'sd32767) begin
      y_wide = 64'sd32767;
      res.saturated = 1'b1;
    end else if (y_wide < -64'sd32768) begin
      y_wide = -64'sd32768;
      res.saturated = 1'b1;
    end
    res.filtered = y_wide[SW-1:0];

    for (int i = 4; i > 0; i--) begin
      x_delay[i] = x_delay[i-1];
      y_delay[i] = y_delay[i-1];
    end
    x_delay[0] = x;
    y_delay[0] = hist_new[HIST_BITS-1:0];
    return res;
  endfunction

  // Build the stimulus, release reset, then wait for the pipeline to drain.
  initial begin
    int mode, len, lvl, dir;
    for (int i = 0; i < 6; i++) ff_coef[i] = to_q20(ff_dec[i]);
    for (int i = 0; i < 5; i++) fb_coef[i] = to_q20(fb_dec[i]);
    for (int i = 0; i < 5; i++) begin
      x_delay[i] = '0;
      y_delay[i] = '0;
    end

    // Directed: silence, full-scale steps both ways, smallest values, Nyquist at the rails.
    samples_to_send = '{16'sd0, 16'sd0};
    repeat (7) samples_to_send.push_back(16'sd32767);
    repeat (7) samples_to_send.push_back(-16'sd32768);
    samples_to_send.push_back(16'sd1);
    samples_to_send.push_back(-16'sd1);
    repeat (2) begin
      samples_to_send.push_back(16'sd32767);
      samples_to_send.push_back(-16'sd32768);
    end
    samples_to_send.push_back(16'sd0);

    // Random: mostly held levels and ramps so the recursion settles, some noise and rail toggling.
    while (samples_to_send.size() < N_ITEMS) begin
      mode = $urandom_range(0, 9);
      len  = $urandom_range(5, 60);
      if (mode < 4) begin
        // hold a level, often at or near a rail
        case ($urandom_range(0, 3))
          0:       lvl = 32767;
          1:       lvl = -32768;
          default: lvl = int'($urandom_range(0, 65535)) - 32768;
        endcase
        repeat (len) samples_to_send.push_back(lvl[SW-1:0]);
      end else if (mode < 7) begin
        // triangle wave folded at the rails
        lvl = int'($urandom_range(0, 65535)) - 32768;
        dir = int'($urandom_range(64, 4096));
        if ($urandom_range(0, 1)) dir = -dir;
        repeat (len) begin
          lvl += dir;
          if (lvl > 32767) begin
            lvl = 32767;
            dir = -dir;
          end else if (lvl < -32768) begin
            lvl = -32768;
            dir = -dir;
          end
          samples_to_send.push_back(lvl[SW-1:0]);
        end
      end else if (mode < 9) begin
        // wideband noise
        repeat (len) samples_to_send.push_back(SW'($urandom_range(0, 65535)));
      end else begin
        // alternate between the rails
        repeat (len) begin
          samples_to_send.push_back(16'sd32767);
          samples_to_send.push_back(-16'sd32768);
        end
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (samples_to_send.size() != 0 || sample_valid || expected_filtered.size() != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Sample driver: predict each accepted request, then present the next one.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        expected_filtered.push_back(filter_step(sample));
      end
      // hold the payload while the request is stalled
      if (!sample_valid || !sample_stall) begin
        if (send_gap > 0) begin
          sample_valid <= 1'b0;
          send_gap = send_gap - 1;
        end else if (samples_to_send.size() > 0) begin
          sample_valid <= 1'b1;
          sample       <= samples_to_send.pop_front();
          if (!quiet_tail && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 14);
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    filt_result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_filtered.size() == 0) begin
          $display("%0t: unexpected result, filtered %0d saturated %0b",
                   $time, filtered, saturated);
          mismatches++;
        end else begin
          want = expected_filtered.pop_front();
          if (filtered !== want.filtered) begin
            $display("%0t: filtered mismatch, expected %0d, actual %0d",
                     $time, want.filtered, filtered);
            mismatches++;
          end
          if (saturated !== want.saturated) begin
            $display("%0t: saturated mismatch, expected %0b, actual %0b",
                     $time, want.saturated, saturated);
            mismatches++;
          end
        end
      end
      // stall the result channel in bursts
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        result_stall <= 1'b0;
        if (!quiet_tail && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 14);
      end
    end
  end

  // Watchdog: give up when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
